// ----- hw/rtl/lpim_pkg.sv -----
// shared types and constants for the linear probing id map
// no dependencies; used by lpim_ctrl, lpim_datapath and linear_probe_id_map

package lpim_pkg;

  localparam int TABLE_SLOTS_DEFAULT = 64;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 15;
  localparam int INDEX_W = 16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_PRESENT  = 2'd2;
  localparam logic [1:0] ST_MISS     = 2'd3;

  localparam logic [INDEX_W-1:0] NO_INDEX = 16'hFFFF;

  // integer mixer multiplier for the home slot
  localparam logic [KEY_W-1:0] MIX_MUL = 32'h85EBCA6B;

  typedef enum logic [2:0] {
    RES_DONE,
    RES_INSERTED,
    RES_PRESENT,
    RES_MISS,
    RES_HIT
  } res_t;

  typedef struct packed {
    logic load_item;
    logic hash_mix;
    logic hash_range;
    logic sweep_start;
    logic sweep_step;
    logic read;
    logic advance;
    logic write_entry;
    logic set_result;
    res_t result;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       slot_empty;
    logic       key_match;
    logic       probe_last;
    logic       sweep_last;
    logic       out_free;
  } stat_t;

endpackage

// ----- hw/rtl/lpim_datapath.sv -----
// datapath of the id map: item registers, hash, slot memory, result registers
// depends on lpim_pkg; driven by lpim_ctrl through cmd_t, reports through stat_t

module lpim_datapath #(
  parameter int TABLE_SLOTS = lpim_pkg::TABLE_SLOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lpim_pkg::cmd_t                     cmd,
  output lpim_pkg::stat_t                    stat,
  input  logic [1:0]                         operation,
  input  logic signed [lpim_pkg::KEY_W-1:0]  key_id,
  input  logic [lpim_pkg::VALUE_W-1:0]       value_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic signed [lpim_pkg::INDEX_W-1:0] index_out,
  output logic [1:0]                         status
);

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int ENTRY_W = 1 + lpim_pkg::KEY_W + lpim_pkg::VALUE_W;
  localparam int RANGE_W = 17 + SLOT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  logic [1:0]                     op_q;
  logic [lpim_pkg::KEY_W-1:0]     key_q;
  logic [lpim_pkg::VALUE_W-1:0]   val_q;
  logic [lpim_pkg::KEY_W-1:0]     mix_q;
  logic [SLOT_W-1:0]              slot;
  logic [SLOT_W-1:0]              slot_next;
  logic [SLOT_W-1:0]              probe_count;
  logic [RANGE_W-1:0]             range_prod;
  logic [lpim_pkg::KEY_W-1:0]     mix_in;
  logic [ENTRY_W-1:0]             mem [TABLE_SLOTS];
  logic [ENTRY_W-1:0]             rd_q;
  logic                           res_found;
  logic [lpim_pkg::INDEX_W-1:0]   res_index;
  logic [1:0]                     res_status;

  assign mix_in     = key_q ^ (key_q >> 16);
  // multiply-shift range reduction works for any table size
  assign range_prod = RANGE_W'(mix_q[31:16]) * RANGE_W'(TABLE_SLOTS);
  assign slot_next  = (slot == LAST_SLOT) ? '0 : slot + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= operation;
      key_q <= key_id;
      val_q <= value_index;
    end
    if (cmd.hash_mix) begin
      mix_q <= mix_in * lpim_pkg::MIX_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= '0;
      probe_count <= '0;
    end else if (cmd.sweep_start) begin
      slot <= '0;
    end else if (cmd.hash_range) begin
      slot        <= range_prod[16 +: SLOT_W];
      probe_count <= '0;
    end else if (cmd.sweep_step) begin
      slot <= slot_next;
    end else if (cmd.advance) begin
      slot        <= slot_next;
      probe_count <= probe_count + SLOT_W'(1);
    end
  end

  // single port slot memory: valid, key, value
  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      mem[slot] <= '0;
    end else if (cmd.write_entry) begin
      mem[slot] <= {1'b1, key_q, val_q};
    end
    if (cmd.read) begin
      rd_q <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      res_found  <= 1'b0;
      res_index  <= lpim_pkg::NO_INDEX;
      res_status <= lpim_pkg::ST_DONE;
      case (cmd.result)
        lpim_pkg::RES_DONE: begin
          res_status <= lpim_pkg::ST_DONE;
        end
        lpim_pkg::RES_INSERTED: begin
          res_status <= lpim_pkg::ST_INSERTED;
        end
        lpim_pkg::RES_PRESENT: begin
          res_found  <= 1'b1;
          res_status <= lpim_pkg::ST_PRESENT;
        end
        lpim_pkg::RES_MISS: begin
          res_status <= lpim_pkg::ST_MISS;
        end
        lpim_pkg::RES_HIT: begin
          res_found  <= 1'b1;
          res_index  <= {1'b0, rd_q[lpim_pkg::VALUE_W-1:0]};
          res_status <= lpim_pkg::ST_DONE;
        end
        default: begin
          res_status <= lpim_pkg::ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found     <= res_found;
      index_out <= res_index;
      status    <= res_status;
    end
  end

  assign stat.op         = op_q;
  assign stat.slot_empty = ~rd_q[ENTRY_W-1];
  assign stat.key_match  = (rd_q[ENTRY_W-2 -: lpim_pkg::KEY_W] == key_q);
  assign stat.probe_last = (probe_count == LAST_SLOT);
  assign stat.sweep_last = (slot == LAST_SLOT);
  assign stat.out_free   = ~out_valid | out_ready;

endmodule

// ----- hw/rtl/lpim_ctrl.sv -----
// controller of the id map: sequences clear sweep, hashing, probing and reply
// depends on lpim_pkg; commands lpim_datapath through cmd_t

module lpim_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lpim_pkg::stat_t stat,
  output lpim_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_SWEEP  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_RANGE  = 7'b0001000,
    S_READ   = 7'b0010000,
    S_CHECK  = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   reply;
  logic   reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    reply_next = reply;
    cmd        = '0;
    cmd.result = lpim_pkg::RES_DONE;
    case (state)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          // the sweep after reset gives no word, a clear operation does
          if (reply) begin
            cmd.set_result = 1'b1;
            cmd.result     = lpim_pkg::RES_DONE;
            reply_next     = 1'b0;
            state_next     = S_RESP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.hash_mix = 1'b1;
        case (stat.op)
          lpim_pkg::OP_CLEAR: begin
            cmd.sweep_start = 1'b1;
            reply_next      = 1'b1;
            state_next      = S_SWEEP;
          end
          lpim_pkg::OP_INSERT, lpim_pkg::OP_LOOKUP: begin
            state_next = S_RANGE;
          end
          default: begin
            cmd.set_result = 1'b1;
            cmd.result     = lpim_pkg::RES_DONE;
            state_next     = S_RESP;
          end
        endcase
      end
      S_RANGE: begin
        cmd.hash_range = 1'b1;
        state_next     = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.slot_empty) begin
          cmd.set_result = 1'b1;
          if (stat.op == lpim_pkg::OP_INSERT) begin
            cmd.write_entry = 1'b1;
            cmd.result      = lpim_pkg::RES_INSERTED;
          end else begin
            cmd.result = lpim_pkg::RES_MISS;
          end
          state_next = S_RESP;
        end else if (stat.key_match) begin
          cmd.set_result = 1'b1;
          cmd.result     = (stat.op == lpim_pkg::OP_INSERT) ? lpim_pkg::RES_PRESENT
                                                            : lpim_pkg::RES_HIT;
          state_next     = S_RESP;
        end else if (stat.probe_last) begin
          // whole table visited: full on insert, not found on lookup
          cmd.set_result = 1'b1;
          cmd.result     = lpim_pkg::RES_MISS;
          state_next     = S_RESP;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_SWEEP;
      end
    endcase
  end

endmodule

// ----- hw/rtl/linear_probe_id_map.sv -----
// linear probing id map: open-addressing map from 32-bit ids to 15-bit indices
// top level; depends on lpim_pkg, lpim_ctrl and lpim_datapath
//
// input channel (in_valid/in_ready) carries operation, key_id, value_index;
// output channel (out_valid/out_ready) carries found, index_out, status.
// one result word is produced for every input word, in order.
// one word is handled at a time: in_ready is high only while the block is idle,
// so a new word is taken only once the previous result has gone to the output register.
// processing from acceptance to out_valid:
//   insert or lookup: the id is hashed to a home slot, then p slots are probed,
//   p from 1 to TABLE_SLOTS; each probe is a registered read of the
//   single-port slot memory followed by the key compare
//   clear: the slots are swept from slot 0, one slot invalidated per cycle
//   unused operation code: no table access, answered with status done.
// results sit in an output register, so the next word is taken while the
// previous result waits; if the receiver still stalls when a new result is
// ready, the block holds it internally and keeps in_ready low.
// after reset the block sweeps all TABLE_SLOTS slots of the slot memory with
// in_ready low, then the table is empty and in_ready rises.

module linear_probe_id_map #(
  parameter int TABLE_SLOTS = lpim_pkg::TABLE_SLOTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          operation,
  input  logic signed [lpim_pkg::KEY_W-1:0]   key_id,
  input  logic [lpim_pkg::VALUE_W-1:0]        value_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                found,
  output logic signed [lpim_pkg::INDEX_W-1:0] index_out,
  output logic [1:0]                          status
);

  lpim_pkg::cmd_t  cmd;
  lpim_pkg::stat_t stat;

  lpim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpim_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .key_id      (key_id),
    .value_index (value_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .index_out   (index_out),
    .status      (status)
  );

endmodule
